// ----- design/bsl_pkg.sv -----
package bsl_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned SepPixels = 3;

  typedef enum logic [1:0] {
    OpOffer = 2'd0,
    OpRead  = 2'd1,
    OpClear = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StInserted  = 3'd0,
    StMergedRep = 3'd1,
    StMergedKep = 3'd2,
    StDiscarded = 3'd3,
    StReadOk    = 3'd4,
    StCleared   = 3'd5,
    StBadIndex  = 3'd6
  } status_e;

  localparam logic CfgCapacity = 1'b0;
  localparam logic CfgMinSep   = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [31:0] flux;
    logic [15:0] tag;
    logic [5:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  position;
    logic [6:0]  count;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [31:0] out_flux;
    logic [15:0] out_tag;
  } rsp_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] flux;
    logic [15:0] tag;
  } entry_t;

endpackage

// ----- design/brightest_source_list.sv -----
// A clear or no-op request goes straight to its result; a read does one memory read first.
// An offer scans the entries in order, and an insertion ahead of other entries shifts them
// down one place; a merge ends the scan at the matching entry.
// Throughput: one request at a time; a request is accepted once the prior result is taken.
// Reset clears the entry count and restores the default configuration; the entry memory
// is not cleared.
module brightest_source_list (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  bsl_pkg::req_t req_i,
  output logic          empty,
  input  logic          pop,
  output bsl_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [7:0]    cfg_data_i
);
  import bsl_pkg::*;

  logic [6:0] capacity_q;
  logic [7:0] min_sep_q;
  logic       q_empty, q_pop;
  req_t       q_data;
  logic       rsp_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 7'(TableDepth);
      min_sep_q  <= 8'(SepPixels << 4);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgCapacity) begin
        capacity_q <= cfg_data_i[6:0];
      end else begin
        min_sep_q <= cfg_data_i;
      end
    end
  end

  bsl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (req_i),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_data)
  );

  bsl_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (!q_empty),
    .req_i       (q_data),
    .req_pop_o   (q_pop),
    .capacity_i  (capacity_q),
    .min_sep_i   (min_sep_q),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp_o),
    .rsp_pop_i   (pop)
  );

  assign empty = !rsp_valid;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> empty) else $error("request taken while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> rsp_o.count <= 7'(TableDepth)) else $error("count overflow");
`endif

endmodule

// ----- design/bsl_fifo.sv -----
module bsl_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bsl_pkg::req_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bsl_pkg::req_t rdata_o
);
  import bsl_pkg::*;

  req_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i && !empty_o) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i && !full_o} - {1'b0, pop_i && !empty_o};
    end
  end

endmodule

// ----- design/bsl_engine.sv -----
module bsl_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  bsl_pkg::req_t req_i,
  output logic          req_pop_o,
  input  logic [6:0]    capacity_i,
  input  logic [7:0]    min_sep_i,
  output logic          rsp_valid_o,
  output bsl_pkg::rsp_t rsp_o,
  input  logic          rsp_pop_i
);
  import bsl_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SScan, SScanChk, STail, SShift, SShiftWr, SRead, SReadOut, SDone
  } state_e;

  state_e          state_q;
  entry_t          mem [TableDepth];
  entry_t          rd_q;
  logic [IdxW-1:0] raddr;
  logic            rd_en;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;
  logic            wr_en;

  req_t            cur_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] cap_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] ins_q;
  logic [CntW-1:0] newcnt_q;
  logic            ins_found_q;
  logic            last_gt_q;
  logic            rsp_valid_q;
  rsp_t            rsp_q;

  logic [16:0]     dx, dy;
  logic [17:0]     man_dist;

  assign dx       = (cur_q.x_pos > rd_q.x) ? {1'b0, cur_q.x_pos - rd_q.x}
                                           : {1'b0, rd_q.x - cur_q.x_pos};
  assign dy       = (cur_q.y_pos > rd_q.y) ? {1'b0, cur_q.y_pos - rd_q.y}
                                           : {1'b0, rd_q.y - cur_q.y_pos};
  assign man_dist = {1'b0, dx} + {1'b0, dy};

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign req_pop_o   = (state_q == SIdle) && req_valid_i && !rsp_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[raddr];
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    raddr   = idx_q[IdxW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_q[IdxW-1:0];
    wr_data = '{x: cur_q.x_pos, y: cur_q.y_pos, flux: cur_q.flux, tag: cur_q.tag};
    case (state_q)
      SScan: begin
        rd_en = 1'b1;
      end
      SRead: begin
        rd_en = 1'b1;
        raddr = cur_q.read_index;
      end
      SScanChk: begin
        if (man_dist < {10'd0, min_sep_i} && cur_q.flux > rd_q.flux) begin
          wr_en = 1'b1;
          wr_addr = idx_q[IdxW-1:0] - IdxW'(1);
        end
      end
      STail: begin
        if ((count_q == '0 || last_gt_q) && count_q < cap_q) begin
          wr_en   = 1'b1;
          wr_addr = count_q[IdxW-1:0];
        end
      end
      SShift: begin
        rd_en = idx_q != ins_q;
        raddr = idx_q[IdxW-1:0] - IdxW'(1);
        wr_en = idx_q == ins_q;
      end
      SShiftWr: begin
        wr_en   = 1'b1;
        wr_data = rd_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      cap_q       <= '0;
      idx_q       <= '0;
      ins_q       <= '0;
      newcnt_q    <= '0;
      ins_found_q <= 1'b0;
      last_gt_q   <= 1'b0;
      cur_q       <= '0;
      rsp_q       <= '0;
    end else begin
      if (rsp_valid_q && rsp_pop_i) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (req_pop_o) begin
            cur_q       <= req_i;
            idx_q       <= '0;
            ins_found_q <= 1'b0;
            last_gt_q   <= 1'b0;
            rsp_q <= '{
              status:   (op_e'(req_i.operation) == OpClear) ? StCleared : StBadIndex,
              position: 6'd0,
              count:    (op_e'(req_i.operation) == OpClear) ? 7'd0 : 7'(count_q),
              out_x:    16'd0,
              out_y:    16'd0,
              out_flux: 32'd0,
              out_tag:  16'd0
            };
            if (capacity_i == 7'd0) begin
              cap_q <= CntW'(1);
            end else if (capacity_i > 7'(TableDepth)) begin
              cap_q <= CntW'(TableDepth);
            end else begin
              cap_q <= CntW'(capacity_i);
            end
            case (op_e'(req_i.operation))
              OpOffer: state_q <= SScan;
              OpRead: state_q <= SRead;
              OpClear: begin
                count_q <= '0;
                state_q <= SDone;
              end
              default: begin
                state_q <= SDone;
              end
            endcase
          end
        end
        SRead: begin
          state_q <= SReadOut;
        end
        SReadOut: begin
          rsp_q.position <= cur_q.read_index;
          if ({1'b0, cur_q.read_index} < count_q) begin
            rsp_q.status   <= StReadOk;
            rsp_q.out_x    <= rd_q.x;
            rsp_q.out_y    <= rd_q.y;
            rsp_q.out_flux <= rd_q.flux;
            rsp_q.out_tag  <= rd_q.tag;
          end
          state_q <= SDone;
        end
        SScan: begin
          if (idx_q >= count_q) begin
            state_q <= STail;
          end else begin
            idx_q   <= idx_q + CntW'(1);
            state_q <= SScanChk;
          end
        end
        SScanChk: begin
          if (man_dist < {10'd0, min_sep_i}) begin
            rsp_q.status   <= (cur_q.flux > rd_q.flux) ? StMergedRep : StMergedKep;
            rsp_q.position <= 6'(idx_q - CntW'(1));
            rsp_q.count    <= 7'(count_q);
            state_q        <= SDone;
          end else begin
            if (!ins_found_q && cur_q.flux > rd_q.flux) begin
              ins_found_q <= 1'b1;
              ins_q       <= idx_q - CntW'(1);
            end
            if (idx_q == count_q) begin
              last_gt_q <= rd_q.flux > cur_q.flux;
            end
            state_q <= SScan;
          end
        end
        STail: begin
          if (count_q == '0 || last_gt_q) begin
            if (count_q < cap_q) begin
              count_q        <= count_q + CntW'(1);
              rsp_q.status   <= StInserted;
              rsp_q.position <= 6'(count_q);
              rsp_q.count    <= 7'(count_q + CntW'(1));
            end else begin
              rsp_q.status <= StDiscarded;
            end
            state_q <= SDone;
          end else if (!ins_found_q || ins_q >= cap_q) begin
            rsp_q.status <= StDiscarded;
            state_q <= SDone;
          end else begin
            newcnt_q <= (count_q < cap_q) ? count_q + CntW'(1) : cap_q;
            idx_q    <= ((count_q < cap_q) ? count_q + CntW'(1) : cap_q) - CntW'(1);
            state_q  <= SShift;
          end
        end
        SShift: begin
          if (idx_q == ins_q) begin
            count_q        <= newcnt_q;
            rsp_q.status   <= StInserted;
            rsp_q.position <= 6'(ins_q);
            rsp_q.count    <= 7'(newcnt_q);
            state_q        <= SDone;
          end else begin
            state_q <= SShiftWr;
          end
        end
        SShiftWr: begin
          idx_q   <= idx_q - CntW'(1);
          state_q <= SShift;
        end
        SDone: begin
          rsp_valid_q <= 1'b1;
          state_q     <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

// ----- verif/brightest_source_list_tb.sv -----
`timescale 1ns / 100ps

module brightest_source_list_tb;
  import bsl_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  push = 1'b0;
  logic  full;
  req_t  req_i = '0;
  logic  empty;
  logic  pop = 1'b0;
  rsp_t  rsp_o;
  logic  cfg_valid_i = 1'b0;
  logic  cfg_ready_o;
  logic  cfg_index_i = 1'b0;
  logic  [7:0] cfg_data_i = '0;

  always #10 clk_i = ~clk_i;

  brightest_source_list i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  entry_t     table_q [TableDepth];
  int unsigned num_entries;
  logic [6:0] cap_reg;
  logic [7:0] sep_reg;

  rsp_t       pending_rsp [$];
  int unsigned mismatches;
  int unsigned idle_cycles;

  typedef struct {
    req_t rq;
    bit   fixed;
    rsp_t want;
  } row_t;

  function automatic logic [16:0] abs_diff(logic [15:0] a, logic [15:0] b);
    return (a > b) ? 17'(a - b) : 17'(b - a);
  endfunction

  function automatic rsp_t predict_source(req_t rq);
    rsp_t r;
    int unsigned cap, p, n;
    bit merged;
    entry_t e;
    r = '0;
    r.status = StBadIndex;
    cap = (cap_reg < 1) ? 1 : (cap_reg > TableDepth ? TableDepth : cap_reg);
    e = '{x: rq.x_pos, y: rq.y_pos, flux: rq.flux, tag: rq.tag};
    case (op_e'(rq.operation))
      OpOffer: begin
        merged = 1'b0;
        for (int i = 0; i < num_entries; i++) begin
          if (!merged && 18'(abs_diff(rq.x_pos, table_q[i].x))
              + 18'(abs_diff(rq.y_pos, table_q[i].y)) < 18'(sep_reg)) begin
            if (rq.flux > table_q[i].flux) begin
              table_q[i] = e;
              r.status = StMergedRep;
            end else begin
              r.status = StMergedKep;
            end
            r.position = 6'(i);
            merged = 1'b1;
          end
        end
        if (!merged) begin
          if (num_entries == 0 || table_q[num_entries-1].flux > rq.flux) begin
            if (num_entries < cap) begin
              table_q[num_entries] = e;
              r.position = 6'(num_entries);
              num_entries++;
              r.status = StInserted;
            end else begin
              r.status = StDiscarded;
            end
          end else begin
            p = 0;
            while (p < num_entries && !(rq.flux > table_q[p].flux)) p++;
            if (p >= num_entries || p >= cap) begin
              r.status = StDiscarded;
            end else begin
              n = (num_entries < cap) ? num_entries + 1 : cap;
              for (int i = n - 1; i > p; i--) table_q[i] = table_q[i-1];
              table_q[p] = e;
              num_entries = n;
              r.position = 6'(p);
              r.status = StInserted;
            end
          end
        end
      end
      OpRead: begin
        r.position = rq.read_index;
        if (rq.read_index < num_entries) begin
          r.status = StReadOk;
          r.out_x = table_q[rq.read_index].x;
          r.out_y = table_q[rq.read_index].y;
          r.out_flux = table_q[rq.read_index].flux;
          r.out_tag = table_q[rq.read_index].tag;
        end
      end
      OpClear: begin
        num_entries = 0;
        r.status = StCleared;
      end
      default: ;
    endcase
    r.count = 7'(num_entries);
    return r;
  endfunction

  task automatic wait_cycles(int unsigned n);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_request(req_t rq);
    int unsigned gap;
    gap = $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      push <= 1'b0;
      wait_cycles(gap);
    end
    req_i <= rq;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    pending_rsp.push_back(predict_source(rq));
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgCapacity) cap_reg = val[6:0];
    else sep_reg = val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    wait_cycles(300);
  endtask

  function automatic req_t offer_req(logic [15:0] x, logic [15:0] y, logic [31:0] f,
                                     logic [15:0] t);
    req_t rq;
    rq = '0;
    rq.operation = OpOffer;
    rq.x_pos = x;
    rq.y_pos = y;
    rq.flux = f;
    rq.tag = t;
    return rq;
  endfunction

  function automatic req_t read_req(logic [5:0] idx);
    req_t rq;
    rq = $bits(req_t)'($urandom());
    rq.operation = OpRead;
    rq.read_index = idx;
    return rq;
  endfunction

  function automatic req_t random_req();
    req_t rq;
    int unsigned k;
    rq = $bits(req_t)'({$urandom(), $urandom(), $urandom()});
    k = $urandom_range(0, 99);
    rq.operation = (k < 70) ? OpOffer : (k < 92) ? OpRead : (k < 96) ? OpClear : OpNone;
    if ($urandom_range(0, 3) != 0) begin
      rq.x_pos = 16'($urandom_range(0, 1023));
      rq.y_pos = 16'($urandom_range(0, 1023));
    end
    if ($urandom_range(0, 2) != 0) rq.flux = $urandom_range(0, 5000);
    if ($urandom_range(0, 1) != 0) rq.read_index = 6'($urandom_range(0, num_entries));
    return rq;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!empty && pop) begin
        rsp_t want;
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %h", rsp_o);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_o !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected st=%0d pos=%0d cnt=%0d x=%h y=%h f=%h t=%h",
                       want.status, want.position, want.count, want.out_x, want.out_y,
                       want.out_flux, want.out_tag);
              $display("          actual   st=%0d pos=%0d cnt=%0d x=%h y=%h f=%h t=%h",
                       rsp_o.status, rsp_o.position, rsp_o.count, rsp_o.out_x, rsp_o.out_y,
                       rsp_o.out_flux, rsp_o.out_tag);
            end
          end
        end
      end
    end
  end

  initial begin : pop_side
    int unsigned gap;
    forever begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        pop <= 1'b0;
        wait_cycles(gap);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty || !rst_ni);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stim
    row_t rows [$];
    row_t rw;
    rsp_t fx;
    int unsigned phase_items;
    mismatches = 0;
    idle_cycles = 0;
    num_entries = 0;
    cap_reg = 7'd64;
    sep_reg = 8'(SepPixels << 4);
    wait_cycles(5);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fx = '0; fx.status = StBadIndex;
    rows.push_back('{read_req(6'd0), 1'b1, fx});
    fx = '0; fx.status = StBadIndex; fx.position = 6'd63;
    rows.push_back('{read_req(6'd63), 1'b1, fx});
    fx = '0; fx.status = StInserted; fx.count = 7'd1;
    rows.push_back('{offer_req(16'd100, 16'd100, 32'd1000, 16'hffff), 1'b1, fx});
    rows.push_back('{offer_req(16'd110, 16'd100, 32'd2000, 16'd1), 1'b0, fx});
    rows.push_back('{offer_req(16'd100, 16'd110, 32'd5, 16'd2), 1'b0, fx});
    rows.push_back('{offer_req(16'hffff, 16'hffff, 32'hffffffff, 16'd3), 1'b0, fx});
    rows.push_back('{offer_req(16'd0, 16'd0, 32'd0, 16'd4), 1'b0, fx});
    rows.push_back('{offer_req(16'd500, 16'd0, 32'd0, 16'd5), 1'b0, fx});
    rows.push_back('{offer_req(16'd900, 16'd900, 32'd2000, 16'd6), 1'b0, fx});
    rows.push_back('{offer_req(16'd1500, 16'd900, 32'd1500, 16'd7), 1'b0, fx});
    for (int i = 0; i < 6; i++) rows.push_back('{read_req(6'(i)), 1'b0, fx});
    rw.rq = '0; rw.rq.operation = OpNone; rw.fixed = 1'b0;
    rows.push_back(rw);
    fx = '0; fx.status = StCleared;
    rw.rq = '0; rw.rq.operation = OpClear; rw.fixed = 1'b1; rw.want = fx;
    rows.push_back(rw);
    rows.push_back('{read_req(6'd0), 1'b0, fx});

    foreach (rows[k]) begin
      send_request(rows[k].rq);
      if (rows[k].fixed) pending_rsp[$] = rows[k].want;
    end
    drain();

    write_reg(CfgCapacity, 8'd1);
    write_reg(CfgMinSep, 8'd0);
    for (int i = 0; i < 8; i++) send_request(random_req());
    drain();
    write_reg(CfgCapacity, 8'd0);
    write_reg(CfgMinSep, 8'd255);
    for (int i = 0; i < 8; i++) send_request(random_req());
    drain();
    write_reg(CfgCapacity, 8'd127);
    for (int i = 0; i < 8; i++) send_request(random_req());
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      phase_items = 230;
      for (int i = 0; i < phase_items; i++) send_request(random_req());
      drain();
      write_reg(CfgCapacity, 8'($urandom_range(0, 80)));
      write_reg(CfgMinSep, 8'($urandom_range(0, 255)));
    end
    drain();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/bsl_pkg.sv
design/bsl_fifo.sv
design/bsl_engine.sv
design/brightest_source_list.sv
verif/brightest_source_list_tb.sv
